>>> rtl/core/dimct_pkg.sv
// ----------------------------------------------------------------------------
// dimct_pkg
// Types, codes and the operation sequence of the double integrator cost unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dimct_pkg;

	localparam int PC_W = 7;
	localparam int RF_AW = 5;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MULQ,
		OP_KMUL,
		OP_DIV,
		OP_INIT,
		OP_STEP,
		OP_OUT
	} op_t;

	typedef enum logic [5:0] {
		S_SX0 = 6'd0,
		S_SX1 = 6'd1,
		S_SV0 = 6'd2,
		S_SV1 = 6'd3,
		S_GX0 = 6'd4,
		S_GX1 = 6'd5,
		S_GV0 = 6'd6,
		S_GV1 = 6'd7,
		S_D0 = 6'd8,
		S_D1 = 6'd9,
		S_DV0 = 6'd10,
		S_DV1 = 6'd11,
		S_P = 6'd12,
		S_Q = 6'd13,
		S_R = 6'd14,
		S_TSQ = 6'd15,
		S_TCU = 6'd16,
		S_FV = 6'd17,
		S_DFV = 6'd18,
		S_RATIO = 6'd19,
		S_T0 = 6'd20,
		S_T1 = 6'd21,
		S_TX = 6'd22,
		S_E = 6'd23,
		S_AA = 6'd24,
		S_BB = 6'd25,
		S_COST = 6'd26,
		S_EST = 6'd32,
		S_ZERO = 6'd33,
		S_K2 = 6'd34,
		S_K4 = 6'd35,
		S_K6 = 6'd36,
		S_K12 = 6'd37,
		S_KM4 = 6'd38,
		S_KM6 = 6'd39,
		S_K24 = 6'd40,
		S_KM36 = 6'd41,
		S_IN0 = 6'd42,
		S_IN1 = 6'd43,
		S_IN2 = 6'd44,
		S_IN3 = 6'd45,
		S_IN4 = 6'd46,
		S_IN5 = 6'd47,
		S_IN6 = 6'd48,
		S_IN7 = 6'd49
	} src_t;

	typedef struct packed {
		op_t  op;
		src_t dst;
		src_t sa;
		src_t sb;
	} instr_t;

	typedef struct packed {
		logic   valid;
		logic   load;
		instr_t instr;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic stop;
	} dp_status_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_ISSUE,
		C_WAIT,
		C_CHECK
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_EXEC,
		PH_MUL,
		PH_DIV
	} dp_phase_t;

	localparam logic [PC_W-1:0] LOOP_PC = 7'd35;
	localparam logic [PC_W-1:0] COST_PC = 7'd50;

	function automatic instr_t mk(op_t op, src_t dst, src_t sa, src_t sb);
		instr_t i;
		i.op = op;
		i.dst = dst;
		i.sa = sa;
		i.sb = sb;
		return i;
	endfunction

	function automatic instr_t prog(logic [PC_W-1:0] pc);
		instr_t i;
		case (pc)
			7'd0:  i = mk(OP_ADD, S_SX0, S_IN0, S_ZERO);
			7'd1:  i = mk(OP_ADD, S_SX1, S_IN1, S_ZERO);
			7'd2:  i = mk(OP_ADD, S_SV0, S_IN2, S_ZERO);
			7'd3:  i = mk(OP_ADD, S_SV1, S_IN3, S_ZERO);
			7'd4:  i = mk(OP_ADD, S_GX0, S_IN4, S_ZERO);
			7'd5:  i = mk(OP_ADD, S_GX1, S_IN5, S_ZERO);
			7'd6:  i = mk(OP_ADD, S_GV0, S_IN6, S_ZERO);
			7'd7:  i = mk(OP_ADD, S_GV1, S_IN7, S_ZERO);
			7'd8:  i = mk(OP_SUB, S_D0, S_GX0, S_SX0);
			7'd9:  i = mk(OP_SUB, S_DV0, S_GV0, S_SV0);
			7'd10: i = mk(OP_SUB, S_D1, S_GX1, S_SX1);
			7'd11: i = mk(OP_SUB, S_DV1, S_GV1, S_SV1);
			7'd12: i = mk(OP_MULQ, S_T0, S_SV0, S_SV0);
			7'd13: i = mk(OP_MULQ, S_T1, S_SV1, S_SV1);
			7'd14: i = mk(OP_ADD, S_T0, S_T0, S_T1);
			7'd15: i = mk(OP_MULQ, S_T1, S_GV0, S_GV0);
			7'd16: i = mk(OP_MULQ, S_TX, S_GV1, S_GV1);
			7'd17: i = mk(OP_ADD, S_T1, S_T1, S_TX);
			7'd18: i = mk(OP_ADD, S_P, S_T0, S_T1);
			7'd19: i = mk(OP_MULQ, S_T0, S_SV0, S_GV0);
			7'd20: i = mk(OP_MULQ, S_T1, S_SV1, S_GV1);
			7'd21: i = mk(OP_ADD, S_T0, S_T0, S_T1);
			7'd22: i = mk(OP_ADD, S_P, S_P, S_T0);
			7'd23: i = mk(OP_KMUL, S_P, S_P, S_KM4);
			7'd24: i = mk(OP_ADD, S_T0, S_SV0, S_GV0);
			7'd25: i = mk(OP_MULQ, S_T0, S_T0, S_D0);
			7'd26: i = mk(OP_ADD, S_T1, S_SV1, S_GV1);
			7'd27: i = mk(OP_MULQ, S_T1, S_T1, S_D1);
			7'd28: i = mk(OP_ADD, S_T0, S_T0, S_T1);
			7'd29: i = mk(OP_KMUL, S_Q, S_T0, S_K24);
			7'd30: i = mk(OP_MULQ, S_T0, S_D0, S_D0);
			7'd31: i = mk(OP_MULQ, S_T1, S_D1, S_D1);
			7'd32: i = mk(OP_ADD, S_T0, S_T0, S_T1);
			7'd33: i = mk(OP_KMUL, S_R, S_T0, S_KM36);
			7'd34: i = mk(OP_INIT, S_T0, S_ZERO, S_ZERO);
			// search round
			7'd35: i = mk(OP_MULQ, S_TSQ, S_EST, S_EST);
			7'd36: i = mk(OP_MULQ, S_TCU, S_TSQ, S_EST);
			7'd37: i = mk(OP_MULQ, S_T0, S_TSQ, S_TSQ);
			7'd38: i = mk(OP_MULQ, S_T1, S_P, S_TSQ);
			7'd39: i = mk(OP_ADD, S_T0, S_T0, S_T1);
			7'd40: i = mk(OP_MULQ, S_T1, S_Q, S_EST);
			7'd41: i = mk(OP_ADD, S_T1, S_T1, S_R);
			7'd42: i = mk(OP_ADD, S_FV, S_T0, S_T1);
			7'd43: i = mk(OP_KMUL, S_T0, S_TCU, S_K4);
			7'd44: i = mk(OP_MULQ, S_T1, S_P, S_EST);
			7'd45: i = mk(OP_KMUL, S_T1, S_T1, S_K2);
			7'd46: i = mk(OP_ADD, S_T0, S_T0, S_T1);
			7'd47: i = mk(OP_ADD, S_DFV, S_T0, S_Q);
			7'd48: i = mk(OP_DIV, S_RATIO, S_FV, S_DFV);
			7'd49: i = mk(OP_STEP, S_T0, S_RATIO, S_FV);
			// cost at the found time
			7'd50: i = mk(OP_MULQ, S_TSQ, S_EST, S_EST);
			7'd51: i = mk(OP_MULQ, S_TCU, S_TSQ, S_EST);
			7'd52: i = mk(OP_ADD, S_COST, S_EST, S_ZERO);
			7'd53: i = mk(OP_MULQ, S_E, S_SV0, S_EST);
			7'd54: i = mk(OP_SUB, S_E, S_D0, S_E);
			7'd55: i = mk(OP_KMUL, S_T0, S_DV0, S_K4);
			7'd56: i = mk(OP_DIV, S_T0, S_T0, S_EST);
			7'd57: i = mk(OP_KMUL, S_T1, S_E, S_K6);
			7'd58: i = mk(OP_DIV, S_T1, S_T1, S_TSQ);
			7'd59: i = mk(OP_SUB, S_AA, S_T0, S_T1);
			7'd60: i = mk(OP_KMUL, S_T0, S_DV0, S_KM6);
			7'd61: i = mk(OP_DIV, S_T0, S_T0, S_TSQ);
			7'd62: i = mk(OP_KMUL, S_T1, S_E, S_K12);
			7'd63: i = mk(OP_DIV, S_T1, S_T1, S_TCU);
			7'd64: i = mk(OP_ADD, S_BB, S_T0, S_T1);
			7'd65: i = mk(OP_MULQ, S_T0, S_DV0, S_AA);
			7'd66: i = mk(OP_ADD, S_COST, S_COST, S_T0);
			7'd67: i = mk(OP_MULQ, S_T0, S_BB, S_E);
			7'd68: i = mk(OP_ADD, S_COST, S_COST, S_T0);
			7'd69: i = mk(OP_MULQ, S_E, S_SV1, S_EST);
			7'd70: i = mk(OP_SUB, S_E, S_D1, S_E);
			7'd71: i = mk(OP_KMUL, S_T0, S_DV1, S_K4);
			7'd72: i = mk(OP_DIV, S_T0, S_T0, S_EST);
			7'd73: i = mk(OP_KMUL, S_T1, S_E, S_K6);
			7'd74: i = mk(OP_DIV, S_T1, S_T1, S_TSQ);
			7'd75: i = mk(OP_SUB, S_AA, S_T0, S_T1);
			7'd76: i = mk(OP_KMUL, S_T0, S_DV1, S_KM6);
			7'd77: i = mk(OP_DIV, S_T0, S_T0, S_TSQ);
			7'd78: i = mk(OP_KMUL, S_T1, S_E, S_K12);
			7'd79: i = mk(OP_DIV, S_T1, S_T1, S_TCU);
			7'd80: i = mk(OP_ADD, S_BB, S_T0, S_T1);
			7'd81: i = mk(OP_MULQ, S_T0, S_DV1, S_AA);
			7'd82: i = mk(OP_ADD, S_COST, S_COST, S_T0);
			7'd83: i = mk(OP_MULQ, S_T0, S_BB, S_E);
			7'd84: i = mk(OP_ADD, S_COST, S_COST, S_T0);
			default: i = mk(OP_OUT, S_T0, S_COST, S_ZERO);
		endcase
		return i;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/dimct_div.sv
// ----------------------------------------------------------------------------
// dimct_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dimct_div #(
	parameter int DW = 32,
	parameter int NW = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/dimct_dp.sv
// ----------------------------------------------------------------------------
// dimct_dp
// Datapath: register file, saturating adder, multiplier, divider, search step.
// ----------------------------------------------------------------------------
`default_nettype none

module dimct_dp import dimct_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_status_t             status,
	input  wire logic [7:0][31:0]  in_vec,
	input  wire logic [16:0]       step_tolerance,
	input  wire logic [30:0]       upper_bound,
	output logic                   result_valid,
	output logic signed [31:0]     path_cost,
	output logic [30:0]            best_time,
	output logic                   hit_limit,
	output logic                   range_error
);

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int SW = ((W > 32) ? W : 32) + 3;
	localparam int NW = W + F;
	localparam int NREG = 1 << RF_AW;

	localparam logic [W-1:0] WMAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN_W = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] WMAX_X = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] WMIN_X = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] C32MAX_X = SW'(32'sh7fffffff);
	localparam logic signed [SW-1:0] C32MIN_X = SW'(32'sh80000000);

	function automatic logic signed [W-1:0] sat_x(logic signed [SW-1:0] v);
		if (v > WMAX_X) begin
			return signed'(WMAX_W);
		end else if (v < WMIN_X) begin
			return signed'(WMIN_W);
		end
		return v[W-1:0];
	endfunction

	function automatic logic ovf_x(logic signed [SW-1:0] v);
		return (v > WMAX_X) || (v < WMIN_X);
	endfunction

	function automatic logic signed [SW-1:0] opnd(src_t s, logic signed [W-1:0] rd,
			logic [W-1:0] est, logic [7:0][31:0] iv);
		logic signed [SW-1:0] v;
		case (s)
			S_EST:  v = signed'(SW'(est));
			S_ZERO: v = '0;
			S_K2:   v = SW'(2);
			S_K4:   v = SW'(4);
			S_K6:   v = SW'(6);
			S_K12:  v = SW'(12);
			S_KM4:  v = SW'(-4);
			S_KM6:  v = SW'(-6);
			S_K24:  v = SW'(24);
			S_KM36: v = SW'(-36);
			S_IN0:  v = SW'(signed'(iv[0]));
			S_IN1:  v = SW'(signed'(iv[1]));
			S_IN2:  v = SW'(signed'(iv[2]));
			S_IN3:  v = SW'(signed'(iv[3]));
			S_IN4:  v = SW'(signed'(iv[4]));
			S_IN5:  v = SW'(signed'(iv[5]));
			S_IN6:  v = SW'(signed'(iv[6]));
			S_IN7:  v = SW'(signed'(iv[7]));
			default: v = SW'(rd);
		endcase
		return v;
	endfunction

	logic signed [W-1:0] rf [NREG];
	logic signed [W-1:0] rd_a_q, rd_b_q;
	dp_phase_t           phase_q, phase_d;
	op_t                 op_q;
	src_t                sa_q, sb_q;
	logic [RF_AW-1:0]    dst_q;
	logic [7:0][31:0]    in_q;
	logic [W-1:0]        est_q, lo_q, hi_q;
	logic                rerr_q, conv_q, done_q, stop_q, res_valid_q;
	logic [2*W-1:0]      prod_s;
	logic                neg_s, kmul_s;
	logic signed [31:0]  cost_q;
	logic [30:0]         time_q;
	logic                hit_q, rerr_out_q;

	logic signed [SW-1:0] a_x, b_x, sum_x, dif_x;
	logic signed [W-1:0]  a_w, b_w;
	logic                 a_f, b_f;
	logic [W-1:0]         ma, mb;
	logic                 neg_ab;

	logic [2*W-1:0]      shifted;
	logic [2*W-1:0]      lim_m;
	logic                mul_ovf;
	logic signed [W-1:0] mul_res;

	logic                div_start, div_done;
	logic [NW-1:0]       div_q, lim_d;
	logic                div_ovf;
	logic signed [W-1:0] div_res;

	logic signed [SW-1:0] est_x, lo_x, hi_x, cand, mag_r, lo_n, hi_n, mid, ratio_e, mag_e;
	logic                 bisect, stop;
	logic signed [SW-1:0] ub_x;
	logic signed [W-1:0]  hi_init;
	logic signed [SW-1:0] cost_x, cost_c;
	logic                 cost_ovf;

	logic                fin, wr_en, flag;
	logic signed [W-1:0] wr_val;

	assign a_x = opnd(sa_q, rd_a_q, est_q, in_q);
	assign b_x = opnd(sb_q, rd_b_q, est_q, in_q);
	assign a_w = sat_x(a_x);
	assign b_w = sat_x(b_x);
	assign a_f = ovf_x(a_x);
	assign b_f = ovf_x(b_x);
	assign sum_x = SW'(a_w) + SW'(b_w);
	assign dif_x = SW'(a_w) - SW'(b_w);
	assign ma = a_w[W-1] ? W'(-a_w) : W'(a_w);
	assign mb = b_w[W-1] ? W'(-b_w) : W'(b_w);
	assign neg_ab = a_w[W-1] ^ b_w[W-1];

	// product scaling and saturation
	assign shifted = kmul_s ? prod_s : (prod_s >> F);
	assign lim_m = neg_s ? (2*W)'(WMIN_W) : (2*W)'(WMAX_W);
	assign mul_ovf = shifted > lim_m;
	assign mul_res = mul_ovf ? (neg_s ? signed'(WMIN_W) : signed'(WMAX_W))
		: (neg_s ? signed'(W'(-shifted[W-1:0])) : signed'(shifted[W-1:0]));

	dimct_div #(
		.DW(W),
		.NW(NW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend({ma, {F{1'b0}}}),
		.divisor(mb),
		.done(div_done),
		.quotient(div_q)
	);

	assign lim_d = neg_s ? NW'(WMIN_W) : NW'(WMAX_W);
	assign div_ovf = div_q > lim_d;
	assign div_res = div_ovf ? (neg_s ? signed'(WMIN_W) : signed'(WMAX_W))
		: (neg_s ? signed'(W'(-div_q[W-1:0])) : signed'(div_q[W-1:0]));

	// safeguarded newton step
	assign est_x = signed'(SW'(est_q));
	assign lo_x = signed'(SW'(lo_q));
	assign hi_x = signed'(SW'(hi_q));
	assign cand = est_x - SW'(a_w);
	assign mag_r = a_w[W-1] ? -SW'(a_w) : SW'(a_w);
	assign bisect = (cand < lo_x) || (cand > hi_x) || ((mag_r <<< 2) < (hi_x - lo_x));
	assign lo_n = (bisect && !(b_w > 0)) ? est_x : lo_x;
	assign hi_n = (bisect && (b_w > 0)) ? est_x : hi_x;
	assign mid = (lo_n + hi_n) >>> 1;
	assign ratio_e = bisect ? (est_x - mid) : SW'(a_w);
	assign mag_e = (ratio_e < 0) ? -ratio_e : ratio_e;
	assign stop = mag_e < signed'(SW'(step_tolerance));

	assign ub_x = signed'(SW'(upper_bound));
	assign hi_init = sat_x(ub_x);

	assign cost_x = SW'(a_w);
	assign cost_ovf = (cost_x > C32MAX_X) || (cost_x < C32MIN_X);
	assign cost_c = (cost_x > C32MAX_X) ? C32MAX_X : ((cost_x < C32MIN_X) ? C32MIN_X : cost_x);

	always_comb begin
		phase_d = phase_q;
		fin = 1'b0;
		wr_en = 1'b0;
		wr_val = a_w;
		flag = 1'b0;
		div_start = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (cmd.valid) begin
					phase_d = PH_EXEC;
				end
			end
			PH_EXEC: begin
				case (op_q)
					OP_ADD: begin
						wr_en = 1'b1;
						wr_val = sat_x(sum_x);
						flag = a_f | b_f | ovf_x(sum_x);
						fin = 1'b1;
						phase_d = PH_IDLE;
					end
					OP_SUB: begin
						wr_en = 1'b1;
						wr_val = sat_x(dif_x);
						flag = a_f | b_f | ovf_x(dif_x);
						fin = 1'b1;
						phase_d = PH_IDLE;
					end
					OP_MULQ, OP_KMUL: begin
						phase_d = PH_MUL;
					end
					OP_DIV: begin
						if (b_w == '0) begin
							wr_en = 1'b1;
							wr_val = (a_w > 0) ? signed'(WMAX_W)
								: ((a_w < 0) ? signed'(WMIN_W) : '0);
							flag = 1'b1;
							fin = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							div_start = 1'b1;
							phase_d = PH_DIV;
						end
					end
					OP_INIT: begin
						flag = ovf_x(ub_x);
						fin = 1'b1;
						phase_d = PH_IDLE;
					end
					OP_OUT: begin
						flag = cost_ovf;
						fin = 1'b1;
						phase_d = PH_IDLE;
					end
					default: begin
						fin = 1'b1;
						phase_d = PH_IDLE;
					end
				endcase
			end
			PH_MUL: begin
				wr_en = 1'b1;
				wr_val = mul_res;
				flag = mul_ovf;
				fin = 1'b1;
				phase_d = PH_IDLE;
			end
			PH_DIV: begin
				if (div_done) begin
					wr_en = 1'b1;
					wr_val = div_res;
					flag = div_ovf;
					fin = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf[dst_q] <= wr_val;
		end
		if (cmd.valid) begin
			rd_a_q <= rf[RF_AW'(cmd.instr.sa)];
			rd_b_q <= rf[RF_AW'(cmd.instr.sb)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q <= 1'b0;
			stop_q <= 1'b0;
			res_valid_q <= 1'b0;
			rerr_q <= 1'b0;
			conv_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q <= fin;
			res_valid_q <= (phase_q == PH_EXEC) && (op_q == OP_OUT);
			if (cmd.load) begin
				rerr_q <= 1'b0;
			end else if (fin) begin
				rerr_q <= rerr_q | flag;
			end
			if ((phase_q == PH_EXEC) && (op_q == OP_STEP)) begin
				stop_q <= stop;
				conv_q <= stop;
			end else if ((phase_q == PH_EXEC) && (op_q == OP_INIT)) begin
				conv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_vec;
		end
		if (cmd.valid) begin
			op_q <= cmd.instr.op;
			sa_q <= cmd.instr.sa;
			sb_q <= cmd.instr.sb;
			dst_q <= RF_AW'(cmd.instr.dst);
		end
		if (phase_q == PH_EXEC) begin
			prod_s <= (2*W)'(ma) * (2*W)'(mb);
			neg_s <= neg_ab;
			kmul_s <= (op_q == OP_KMUL);
			if (op_q == OP_INIT) begin
				lo_q <= '0;
				hi_q <= W'(hi_init);
				est_q <= W'(hi_init) >> 1;
			end else if (op_q == OP_STEP) begin
				lo_q <= W'(lo_n);
				hi_q <= W'(hi_n);
				est_q <= bisect ? W'(mid) : W'(cand);
			end else if (op_q == OP_OUT) begin
				cost_q <= 32'(cost_c);
				time_q <= 31'(est_q);
				hit_q <= !conv_q;
				rerr_out_q <= rerr_q | cost_ovf;
			end
		end
	end

	assign status.done = done_q;
	assign status.stop = stop_q;
	assign result_valid = res_valid_q;
	assign path_cost = cost_q;
	assign best_time = time_q;
	assign hit_limit = hit_q;
	assign range_error = rerr_out_q;

endmodule

`default_nettype wire

>>> rtl/core/dimct_ctrl.sv
// ----------------------------------------------------------------------------
// dimct_ctrl
// Sequencer: steps the operation list and runs the root search loop.
// ----------------------------------------------------------------------------
`default_nettype none

module dimct_ctrl import dimct_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] iteration_limit,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	ctrl_state_t     state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic [7:0]      cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		cnt_d = cnt_q;
		cmd.valid = 1'b0;
		cmd.load = 1'b0;
		cmd.instr = prog(pc_q);
		case (state_q)
			C_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					pc_d = '0;
					cnt_d = '0;
					state_d = C_ISSUE;
				end
			end
			C_ISSUE: begin
				cmd.valid = 1'b1;
				state_d = C_WAIT;
			end
			C_WAIT: begin
				if (status.done) begin
					case (cmd.instr.op)
						OP_INIT: begin
							state_d = C_CHECK;
						end
						OP_STEP: begin
							if (status.stop) begin
								pc_d = COST_PC;
								state_d = C_ISSUE;
							end else begin
								cnt_d = cnt_q + 1'b1;
								state_d = C_CHECK;
							end
						end
						OP_OUT: begin
							state_d = C_IDLE;
						end
						default: begin
							pc_d = pc_q + 1'b1;
							state_d = C_ISSUE;
						end
					endcase
				end
			end
			C_CHECK: begin
				pc_d = (cnt_q < iteration_limit) ? LOOP_PC : COST_PC;
				state_d = C_ISSUE;
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	assign busy = (state_q != C_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/double_integrator_min_cost_time_unit.sv
// ----------------------------------------------------------------------------
// double_integrator_min_cost_time_unit
// Optimal steering time and cost of a 2D double integrator, fixed point.
//
// usage
//   start is taken while busy is low; the eight start/goal position and
//   velocity words transfer with it. busy stays high until the result.
//   result_valid is high for one cycle with path_cost, best_time, hit_limit
//   and range_error; there is no backpressure, the receiver must take it.
//   configuration writes transfer on cfg_valid/cfg_ready (ready always high),
//   index 0 step tolerance, 1 iteration limit, 2 search upper bound; write
//   only while busy is low.
// operation
//   one shared multiplier, an adder, a subtractor and a restoring divider,
//   sequenced op by op through a register file; each op is issued, run in
//   the datapath's exec phase (plus a mul or div phase for those ops) and
//   acknowledged by done before the next issue. one item at a time; busy
//   falls the cycle after result_valid.
// reset
//   arst_n clears the sequencer and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module double_integrator_min_cost_time_unit import dimct_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] start_pos_x,
	input  wire logic signed [31:0] start_pos_y,
	input  wire logic signed [31:0] start_vel_x,
	input  wire logic signed [31:0] start_vel_y,
	input  wire logic signed [31:0] goal_pos_x,
	input  wire logic signed [31:0] goal_pos_y,
	input  wire logic signed [31:0] goal_vel_x,
	input  wire logic signed [31:0] goal_vel_y,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	output logic                    result_valid,
	output logic signed [31:0]      path_cost,
	output logic [30:0]             best_time,
	output logic                    hit_limit,
	output logic                    range_error
);

	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_UB = 2'd2;

	logic [16:0]      tol_q;
	logic [7:0]       limit_q;
	logic [30:0]      ub_q;
	logic [7:0][31:0] in_vec;
	dp_cmd_t          cmd;
	dp_status_t       status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 17'd66;
			limit_q <= 8'd50;
			ub_q <= 31'd655360;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOL:   tol_q <= cfg_data[16:0];
				REG_LIMIT: limit_q <= cfg_data[7:0];
				REG_UB:    ub_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	assign in_vec[0] = start_pos_x;
	assign in_vec[1] = start_pos_y;
	assign in_vec[2] = start_vel_x;
	assign in_vec[3] = start_vel_y;
	assign in_vec[4] = goal_pos_x;
	assign in_vec[5] = goal_pos_y;
	assign in_vec[6] = goal_vel_x;
	assign in_vec[7] = goal_vel_y;

	dimct_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.iteration_limit(limit_q),
		.cmd(cmd),
		.status(status)
	);

	dimct_dp #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_vec(in_vec),
		.step_tolerance(tol_q),
		.upper_bound(ub_q),
		.result_valid(result_valid),
		.path_cost(path_cost),
		.best_time(best_time),
		.hit_limit(hit_limit),
		.range_error(range_error)
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double integrator steering cost unit. Items go
// in through the start/busy command port. A built-in fixed point predictor
// computes the expected cost, time and flags for each accepted item. Every
// result strobe is checked field by field against the oldest prediction.
// Runs a directed set, then random items under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import dimct_pkg::*;

	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_ITER = 2'd1;
	localparam logic [1:0] REG_UB = 2'd2;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic signed [31:0] sx, sy, svx, svy, gx, gy, gvx, gvy;
	} steer_in_t;

	typedef struct packed {
		logic signed [31:0] cost;
		logic [30:0]        t;
		logic               lim;
		logic               err;
	} steer_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	steer_in_t item;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;
	logic result_valid;
	logic signed [31:0] path_cost;
	logic [30:0] best_time;
	logic hit_limit;
	logic range_error;

	steer_res_t pending_costs[$];
	int err_count = 0;
	int idle_cycles = 0;
	bit no_idle = 0;
	bit sat_seen;
	longint tol_reg = 66;
	int iter_reg = 50;
	longint ub_reg = 655360;

	double_integrator_min_cost_time_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_pos_x(item.sx), .start_pos_y(item.sy),
		.start_vel_x(item.svx), .start_vel_y(item.svy),
		.goal_pos_x(item.gx), .goal_pos_y(item.gy),
		.goal_vel_x(item.gvx), .goal_vel_y(item.gvy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .path_cost(path_cost),
		.best_time(best_time), .hit_limit(hit_limit), .range_error(range_error)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// fixed point arithmetic of the block

	function automatic longint clampw(longint v);
		if (v > WMAX) begin
			sat_seen = 1;
			return WMAX;
		end
		if (v < WMIN) begin
			sat_seen = 1;
			return WMIN;
		end
		return v;
	endfunction

	function automatic logic [63:0] magn(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint from_mag(logic [63:0] m, bit neg);
		logic [63:0] lim;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		if (m > lim) begin
			sat_seen = 1;
			return neg ? WMIN : WMAX;
		end
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] pr;
		bit neg;
		pr = {64'd0, magn(a)} * {64'd0, magn(b)};
		neg = (a < 0) != (b < 0);
		if (pr[127:80] != 0) begin
			sat_seen = 1;
			return neg ? WMIN : WMAX;
		end
		return from_mag(pr[79:16], neg);
	endfunction

	function automatic longint fx_div(longint a, longint b);
		logic [63:0] ua, ub;
		bit neg;
		if (b == 0) begin
			sat_seen = 1;
			return a > 0 ? WMAX : (a < 0 ? WMIN : 0);
		end
		ua = magn(a);
		ub = magn(b);
		neg = (a < 0) != (b < 0);
		if (ua / ub > 64'd65536) begin
			sat_seen = 1;
			return neg ? WMIN : WMAX;
		end
		return from_mag((ua << 16) / ub, neg);
	endfunction

	function automatic steer_res_t predict_steer(steer_in_t s);
		longint x0[2], v0[2], x1[2], v1[2], d[2], dv[2];
		longint p, q, r, lo, hi, est, t2, t3, fv, dfv, ratio, cand, cost, e, a, b;
		int k;
		int i;
		bit conv;
		steer_res_t res;
		sat_seen = 0;
		conv = 0;
		x0[0] = s.sx; x0[1] = s.sy; v0[0] = s.svx; v0[1] = s.svy;
		x1[0] = s.gx; x1[1] = s.gy; v1[0] = s.gvx; v1[1] = s.gvy;
		for (k = 0; k < 2; k++) begin
			d[k] = clampw(x1[k] - x0[k]);
			dv[k] = clampw(v1[k] - v0[k]);
		end
		p = clampw(clampw(fx_mul(v0[0], v0[0]) + fx_mul(v0[1], v0[1]))
			+ clampw(fx_mul(v1[0], v1[0]) + fx_mul(v1[1], v1[1])));
		p = clampw(p + clampw(fx_mul(v0[0], v1[0]) + fx_mul(v0[1], v1[1])));
		p = clampw(-4 * p);
		q = clampw(24 * clampw(fx_mul(clampw(v0[0] + v1[0]), d[0])
			+ fx_mul(clampw(v0[1] + v1[1]), d[1])));
		r = clampw(-36 * clampw(fx_mul(d[0], d[0]) + fx_mul(d[1], d[1])));
		lo = 0;
		hi = ub_reg;
		est = (lo + hi) >>> 1;
		for (i = 0; i < iter_reg; i++) begin
			t2 = fx_mul(est, est);
			t3 = fx_mul(t2, est);
			fv = clampw(clampw(fx_mul(t2, t2) + fx_mul(p, t2)) + clampw(fx_mul(q, est) + r));
			dfv = clampw(clampw(clampw(4 * t3) + clampw(2 * fx_mul(p, est))) + q);
			ratio = fx_div(fv, dfv);
			cand = est - ratio;
			if (cand < lo || cand > hi || 4 * longint'(magn(ratio)) < hi - lo) begin
				if (fv > 0)
					hi = est;
				else
					lo = est;
				ratio = est - ((lo + hi) >>> 1);
				cand = est - ratio;
			end
			est = cand;
			if (longint'(magn(ratio)) < tol_reg) begin
				conv = 1;
				break;
			end
		end
		t2 = fx_mul(est, est);
		t3 = fx_mul(t2, est);
		cost = est;
		for (k = 0; k < 2; k++) begin
			e = clampw(d[k] - fx_mul(v0[k], est));
			a = clampw(fx_div(clampw(4 * dv[k]), est) - fx_div(clampw(6 * e), t2));
			b = clampw(fx_div(clampw(-6 * dv[k]), t2) + fx_div(clampw(12 * e), t3));
			cost = clampw(cost + fx_mul(dv[k], a));
			cost = clampw(cost + fx_mul(b, e));
		end
		res.cost = 32'(cost);
		res.t = 31'(est);
		res.lim = !conv;
		res.err = sat_seen;
		return res;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin
		steer_res_t want;
		if (arst_n && result_valid) begin
			if (pending_costs.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = pending_costs.pop_front();
				if (path_cost !== want.cost) report("path_cost", path_cost, want.cost);
				if (best_time !== want.t) report("best_time", best_time, want.t);
				if (hit_limit !== want.lim) report("hit_limit", hit_limit, want.lim);
				if (range_error !== want.err) report("range_error", range_error, want.err);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_item(input steer_in_t s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		while (busy) @(negedge clk);
		repeat (gap) @(negedge clk);
		@(negedge clk);
		item = s;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_costs.push_back(predict_steer(s));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		wait (pending_costs.size() == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TOL: tol_reg = val[16:0];
			REG_ITER: iter_reg = val[7:0];
			REG_UB: ub_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regs(input logic [30:0] tol, input logic [30:0] iters,
			input logic [30:0] ub);
		write_reg(REG_TOL, tol);
		write_reg(REG_ITER, iters);
		write_reg(REG_UB, ub);
	endtask

	function automatic steer_in_t rand_item();
		steer_in_t s;
		if ($urandom_range(0, 4) == 0) begin
			s = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		end else begin
			s.sx = int'($urandom_range(0, 2097152)) - 1048576;
			s.sy = int'($urandom_range(0, 2097152)) - 1048576;
			s.gx = int'($urandom_range(0, 2097152)) - 1048576;
			s.gy = int'($urandom_range(0, 2097152)) - 1048576;
			s.svx = int'($urandom_range(0, 524288)) - 262144;
			s.svy = int'($urandom_range(0, 524288)) - 262144;
			s.gvx = int'($urandom_range(0, 524288)) - 262144;
			s.gvy = int'($urandom_range(0, 524288)) - 262144;
		end
		return s;
	endfunction

	task automatic test_directed();
		steer_in_t s;
		no_idle = 1;
		send_item('0);
		send_item({8{32'h7fffffff}});
		send_item({8{32'h80000000}});
		send_item({32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
		s = '0;
		s.gx = 32'sh00030000;
		s.gy = -32'sh00010000;
		send_item(s);
		s.svx = 32'sh00010000;
		s.gvy = -32'sh00020000;
		send_item(s);
		s = '0;
		s.sx = 32'sh00050000;
		s.svx = 32'sh00008000;
		s.gvx = 32'sh00008000;
		send_item(s);
		send_item({8{32'hffffffff}});
		no_idle = 0;
		send_item({8{32'h00000001}});
		send_item({8{32'h55555555}});
		send_item({8{32'haaaaaaaa}});
	endtask

	task automatic test_special_regs();
		// zero iteration limit keeps the start estimate
		set_regs(66, 0, 655360);
		send_item(rand_item());
		send_item('0);
		// zero bracket
		set_regs(66, 10, 0);
		send_item(rand_item());
		send_item('0);
		// widest bracket, coarsest tolerance
		set_regs(131071, 20, 31'h7fffffff);
		send_item(rand_item());
		send_item({8{32'h7fffffff}});
		// zero tolerance never converges, narrowest useful bracket
		set_regs(0, 6, 65536);
		send_item(rand_item());
		set_regs(1, 255, 655360);
		send_item(rand_item());
		send_item(rand_item());
	endtask

	task automatic test_random_phase(input logic [30:0] tol, input logic [30:0] iters,
			input logic [30:0] ub, input int count);
		set_regs(tol, iters, ub);
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
			send_item(rand_item());
		end
		no_idle = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TOL;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_special_regs();
		test_random_phase(66, 50, 655360, 30);
		test_random_phase(1, 16, 327680, 70);
		test_random_phase(65536, 4, 31'h7fffffff, 60);
		test_random_phase(200, 255, 65536, 4);
		test_random_phase(2, 8, 1310720, 70);
		test_random_phase(66, 50, 655360, 46);
		wait (pending_costs.size() == 0);
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
